>>> hdl/elpb_pkg.sv
// elpb_pkg: shared types, codes and constants of the expert load phase balancer.
// No dependencies; used by elpb_count_mem and expert_load_phase_balancer_top.
`timescale 1ns / 1ps

package elpb_pkg;

  localparam int MAX_EXPERTS = 64;
  localparam int COUNT_WIDTH = 32;
  localparam int TOTAL_WIDTH = 38;
  localparam int ID_W        = $clog2(MAX_EXPERTS);
  localparam int NUM_W       = 7;
  localparam int TC_W        = 48;
  localparam int CFG_W       = 48;
  localparam int CFG_IDX_W   = 2;
  // multiplier of the load: N * 10
  localparam int K_W         = $clog2(MAX_EXPERTS * 10 + 1);
  // total * 11 fits in TOTAL_WIDTH + 4 bits
  localparam int T11_W       = TOTAL_WIDTH + 4;
  localparam int CMP_W       = (COUNT_WIDTH + K_W > T11_W) ? COUNT_WIDTH + K_W : T11_W;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_EXPERTS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIALIZE_FROM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EQUILIBRIUM_FROM = 2'd2;

  localparam logic [NUM_W-1:0] NUM_EXPERTS_RST      = NUM_W'(64);
  localparam logic [TC_W-1:0]  SPECIALIZE_FROM_RST  = TC_W'(1000000);
  localparam logic [TC_W-1:0]  EQUILIBRIUM_FROM_RST = TC_W'(50000000);

  // noise levels in signed Q2.14
  localparam logic signed [15:0] NOISE_EXPLORE = 16'sd16384;
  localparam logic signed [15:0] NOISE_ANNEAL  = 16'sd1638;
  localparam logic signed [15:0] NOISE_PENALTY = -16'sd8192;
  localparam logic signed [15:0] NOISE_MINIMAL = 16'sd164;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_PHASE  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_RANDOM  = 2'd0,
    PH_SPECIAL = 2'd1,
    PH_EQUIL   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_EXPLORE = 2'd0,
    KIND_ANNEAL  = 2'd1,
    KIND_PENALTY = 2'd2,
    KIND_MINIMAL = 2'd3
  } kind_e;

  typedef struct packed {
    op_e              op;
    logic [ID_W-1:0]  expert;
    logic [TC_W-1:0]  token_count;
  } in_t;

  typedef struct packed {
    kind_e              noise_kind;
    logic signed [15:0] noise_q14;
    phase_e             phase_now;
    logic               bad_expert;
  } out_t;

  // write request into the counter memory
  typedef struct packed {
    logic                   en;
    logic [ID_W-1:0]        addr;
    logic [COUNT_WIDTH-1:0] data;
  } cnt_wr_t;

  function automatic logic signed [15:0] noise_of(kind_e kind);
    logic signed [15:0] val;
    unique case (kind)
      KIND_EXPLORE: val = NOISE_EXPLORE;
      KIND_ANNEAL:  val = NOISE_ANNEAL;
      KIND_PENALTY: val = NOISE_PENALTY;
      KIND_MINIMAL: val = NOISE_MINIMAL;
      default:      val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> hdl/expert_load_phase_balancer_top.sv
// expert_load_phase_balancer_top: op decode, phase tracking, load test and result register.
// Depends on elpb_pkg and elpb_count_mem.
`timescale 1ns / 1ps

// Each input beat carries one op and yields exactly one result beat. The counter
// read is issued with the beat, and its data is registered at the edge that
// accepts the beat. The read state follows, and the evaluate state writes the
// counter back and loads the result register at its closing edge, which waits
// while the result register is held. The input stays stalled until the evaluate
// state hands off, so the block takes no new beat before the last one is through.
// This is set by the read-modify-write of the single counter memory.
// A held result stalls evaluation only if the result register is still occupied
// when the next item reaches evaluation.
// The counters need no clearing pass after reset. A valid bit per entry makes
// unwritten counters read as zero, so items are taken from the first cycle out of
// reset. Configuration writes land at once and must only be made while the block
// is idle.
module expert_load_phase_balancer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [elpb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [elpb_pkg::CFG_W-1:0]          cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  elpb_pkg::in_t                       in_data_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output elpb_pkg::out_t                      out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EX   = 3'b100
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [elpb_pkg::NUM_W-1:0] num_q;
  logic [elpb_pkg::TC_W-1:0]  spec_from_q;
  logic [elpb_pkg::TC_W-1:0]  equil_from_q;

  // item held through read and evaluate
  elpb_pkg::in_t item_q;

  // running totals; tot11_q tracks total_q * 11 so the load test needs no second multiply
  logic [elpb_pkg::TOTAL_WIDTH-1:0] total_q, total_d;
  logic [elpb_pkg::T11_W-1:0]       tot11_q, tot11_d;
  elpb_pkg::phase_e                 phase_q, phase_d;

  // result register
  logic           out_valid_q, out_valid_d;
  elpb_pkg::out_t out_data_q, out_data_d;

  logic                             accept;
  logic                             out_free;
  logic                             commit;
  logic [elpb_pkg::COUNT_WIDTH-1:0] load;
  logic [elpb_pkg::NUM_W-1:0]       n_eff;
  logic [elpb_pkg::K_W-1:0]         k_mul;
  logic [elpb_pkg::CMP_W-1:0]       load_prod;
  logic                             over_avg;
  logic                             bad;
  elpb_pkg::cnt_wr_t                cnt_wr;
  elpb_pkg::kind_e                  kind;

  // ---------------------------------------------------------------------------
  // Configuration: take writes immediately, drop writes beyond the register list
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q        <= elpb_pkg::NUM_EXPERTS_RST;
      spec_from_q  <= elpb_pkg::SPECIALIZE_FROM_RST;
      equil_from_q <= elpb_pkg::EQUILIBRIUM_FROM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        elpb_pkg::CFG_NUM_EXPERTS:      num_q        <= cfg_wdata_i[elpb_pkg::NUM_W-1:0];
        elpb_pkg::CFG_SPECIALIZE_FROM:  spec_from_q  <= cfg_wdata_i[elpb_pkg::TC_W-1:0];
        elpb_pkg::CFG_EQUILIBRIUM_FROM: equil_from_q <= cfg_wdata_i[elpb_pkg::TC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and sequencing
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  // the result register can take a new beat when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == S_EX) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_RD;
      S_RD:   state_d = S_EX;
      S_EX:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Counter memory: read on accept, write back on commit
  // ---------------------------------------------------------------------------
  elpb_count_mem u_count_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_data_i.expert),
    .rd_data_o (load),
    .wr_i      (cnt_wr)
  );

  // ---------------------------------------------------------------------------
  // Evaluate
  // ---------------------------------------------------------------------------
  assign n_eff = (num_q > elpb_pkg::NUM_W'(elpb_pkg::MAX_EXPERTS))
               ? elpb_pkg::NUM_W'(elpb_pkg::MAX_EXPERTS) : num_q;
  assign bad   = elpb_pkg::NUM_W'(item_q.expert) >= n_eff;
  assign k_mul = elpb_pkg::K_W'(n_eff) * elpb_pkg::K_W'(10);

  // load * N * 10 > total * 11 means load above 1.1 times the average
  assign load_prod = elpb_pkg::CMP_W'(load) * elpb_pkg::CMP_W'(k_mul);
  assign over_avg  = load_prod > elpb_pkg::CMP_W'(tot11_q);

  always_comb begin
    cnt_wr      = '0;
    total_d     = total_q;
    tot11_d     = tot11_q;
    phase_d     = phase_q;
    kind        = elpb_pkg::KIND_EXPLORE;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    cnt_wr.addr = item_q.expert;
    cnt_wr.data = load + elpb_pkg::COUNT_WIDTH'(1);

    unique case (phase_q)
      elpb_pkg::PH_RANDOM:  kind = elpb_pkg::KIND_EXPLORE;
      elpb_pkg::PH_SPECIAL: kind = elpb_pkg::KIND_ANNEAL;
      default: begin
        if (bad || !over_avg) begin
          kind = elpb_pkg::KIND_MINIMAL;
        end else begin
          kind = elpb_pkg::KIND_PENALTY;
        end
      end
    endcase

    if (commit) begin
      out_valid_d           = 1'b1;
      out_data_d.noise_kind = elpb_pkg::KIND_EXPLORE;
      out_data_d.noise_q14  = '0;
      out_data_d.bad_expert = 1'b0;

      unique case (item_q.op)
        elpb_pkg::OP_RECORD: begin
          out_data_d.bad_expert = bad;
          // a saturated counter holds and the total is left alone
          if (!bad && (load != {elpb_pkg::COUNT_WIDTH{1'b1}})) begin
            cnt_wr.en = 1'b1;
            if (total_q != {elpb_pkg::TOTAL_WIDTH{1'b1}}) begin
              total_d = total_q + elpb_pkg::TOTAL_WIDTH'(1);
              tot11_d = tot11_q + elpb_pkg::T11_W'(11);
            end
          end
        end
        elpb_pkg::OP_PHASE: begin
          priority if (item_q.token_count < spec_from_q) begin
            phase_d = elpb_pkg::PH_RANDOM;
          end else if (item_q.token_count < equil_from_q) begin
            phase_d = elpb_pkg::PH_SPECIAL;
          end else begin
            phase_d = elpb_pkg::PH_EQUIL;
          end
        end
        elpb_pkg::OP_QUERY: begin
          out_data_d.bad_expert = bad;
          out_data_d.noise_kind = kind;
          out_data_d.noise_q14  = elpb_pkg::noise_of(kind);
        end
        default: ;
      endcase

      out_data_d.phase_now = phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      tot11_q     <= '0;
      phase_q     <= elpb_pkg::PH_RANDOM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      tot11_q     <= tot11_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // read and write-back of the counter memory never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && cnt_wr.en))
    else $error("counter read and write in the same cycle");

  // an accepted beat always moves on to the memory read
  a_accept_to_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RD))
    else $error("accepted beat did not advance to read");

  // the scaled total stays equal to eleven times the total
  a_tot11_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot11_q == ({total_q, 3'b000} + {2'b00, total_q, 1'b0} + {4'b0000, total_q}))
    else $error("scaled total lost track of total");

  // the total only grows
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (total_q >= $past(total_q)))
    else $error("total decreased");

  // a bad id never draws a penalty
  a_bad_no_penalty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.bad_expert) |-> (out_data_q.noise_kind != elpb_pkg::KIND_PENALTY))
    else $error("penalty reported for a bad expert id");

endmodule

>>> hdl/elpb_count_mem.sv
// elpb_count_mem: per-expert assignment counters in a synchronous memory.
// Depends on elpb_pkg; valid bits make never-written entries read as zero.
`timescale 1ns / 1ps

module elpb_count_mem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [elpb_pkg::ID_W-1:0]       rd_addr_i,
  output logic [elpb_pkg::COUNT_WIDTH-1:0] rd_data_o,
  input  elpb_pkg::cnt_wr_t               wr_i
);

  logic [elpb_pkg::COUNT_WIDTH-1:0] mem [elpb_pkg::MAX_EXPERTS];
  logic [elpb_pkg::MAX_EXPERTS-1:0] vld_q;
  logic [elpb_pkg::COUNT_WIDTH-1:0] rdata_q;
  logic                             rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule
